>>> rtl/core/sdpe_pkg.sv
package sdpe_pkg;

  localparam int unsigned SymW       = 8;
  localparam int unsigned MaxSymbols = 6;
  localparam int unsigned CntW       = 3;
  localparam int unsigned CodeW      = SymW * MaxSymbols;

  localparam logic [SymW-1:0] SymNone = 8'h00;
  localparam logic [SymW-1:0] SymP    = "P";
  localparam logic [SymW-1:0] SymT    = "T";
  localparam logic [SymW-1:0] SymK    = "K";
  localparam logic [SymW-1:0] SymM    = "M";
  localparam logic [SymW-1:0] SymR    = "R";
  localparam logic [SymW-1:0] SymS    = "S";
  localparam logic [SymW-1:0] SymX    = "X";
  localparam logic [SymW-1:0] SymJ    = "J";
  localparam logic [SymW-1:0] SymH    = "H";
  localparam logic [SymW-1:0] SymY    = "Y";
  localparam logic [SymW-1:0] SymL    = "L";
  localparam logic [SymW-1:0] SymA    = "A";

  typedef struct packed {
    logic [7:0] char_code;
    logic       word_end;
  } in_word_t;

  typedef struct packed {
    logic [CodeW-1:0] main_code;
    logic [CntW-1:0]  primary_length;
    logic [CodeW-1:0] alt_code;
    logic [CntW-1:0]  secondary_length;
  } out_word_t;

  typedef struct packed {
    logic [SymW-1:0] prim;
    logic [SymW-1:0] sec;
    logic            consumed;
  } letter_code_t;

  // One letter with optional one-character lookahead; zero symbol = nothing.
  function automatic letter_code_t code_letter(input logic [7:0] ch, input logic first,
                                               input logic has_nx, input logic [7:0] nx);
    letter_code_t r;
    logic         front;
    r.prim     = SymNone;
    r.sec      = SymNone;
    r.consumed = 1'b0;
    front      = has_nx && (nx == "e" || nx == "i");
    case (ch)
      "b", "v", "p": begin r.prim = SymP; r.sec = SymP; end
      "d", "t":      begin r.prim = SymT; r.sec = SymT; end
      "k", "q":      begin r.prim = SymK; r.sec = SymK; end
      "m", "n":      begin r.prim = SymM; r.sec = SymM; end
      "r":           begin r.prim = SymR; r.sec = SymR; end
      "s", "x":      begin r.prim = SymS; r.sec = SymX; end
      "c", "z": begin
        if (front) begin
          r.prim = SymS; r.sec = SymS;
        end else if (has_nx && nx == "h") begin
          r.prim = SymX; r.sec = SymX; r.consumed = 1'b1;
        end else begin
          r.prim = SymK; r.sec = SymK;
        end
      end
      "g", "j": begin
        if (front) begin
          r.prim = SymJ; r.sec = SymH;
        end else begin
          r.prim = SymK; r.sec = SymK;
        end
      end
      "l": begin
        if (has_nx && nx == "l") begin
          r.prim = SymY; r.sec = SymL; r.consumed = 1'b1;
        end else begin
          r.prim = SymL; r.sec = SymL;
        end
      end
      "h": begin
        if (first) r.prim = SymH;
      end
      "a", "e", "i", "o", "u": begin
        if (first) begin
          r.prim = SymA; r.sec = SymA;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/spanish_double_phonetic_encoder.sv
// Channel  Dir  Handshake                  Word
// in       in   in_valid_i / in_ready_o    in_data_i  (char_code, word_end)
// out      out  out_valid_o / out_ready_i  out_data_o (codes and lengths)
//
// One character per cycle; the result for a word appears in the cycle after
// the word's last character is taken, from a single output register.
// The held lookahead character is coded in the cycle the next one arrives.
// Input stalls only while a result sits in the output register and out_ready_i
// is low. Reset clears the held character and both partial codes.
module spanish_double_phonetic_encoder #(
  parameter int unsigned CODE_LENGTH = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sdpe_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sdpe_pkg::out_word_t out_data_o
);

  localparam int unsigned SymLimit =
    (CODE_LENGTH > sdpe_pkg::MaxSymbols) ? sdpe_pkg::MaxSymbols : CODE_LENGTH;

  logic [7:0] pend_char_q;
  logic       pend_valid_q, pend_first_q, skip_q;
  logic       out_valid_q;
  sdpe_pkg::out_word_t out_data_q;

  logic accept, last, en_a, en_b, skip_n, first_n;
  logic [7:0] c;
  sdpe_pkg::letter_code_t code_a, code_b;
  logic [sdpe_pkg::SymW-1:0]  pa, sa, pb, sb;
  logic [sdpe_pkg::CodeW-1:0] prim_code, sec_code;
  logic [sdpe_pkg::CntW-1:0]  prim_len, sec_len;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign c          = in_data_i.char_code;
  assign last       = in_data_i.word_end;

  always_comb begin
    code_a  = sdpe_pkg::code_letter(pend_char_q, pend_first_q, 1'b1, c);
    en_a    = pend_valid_q && !skip_q;
    skip_n  = en_a && code_a.consumed;
    first_n = pend_valid_q ? 1'b0 : pend_first_q;
    // final letter of the word: no lookahead
    code_b  = sdpe_pkg::code_letter(c, first_n, 1'b0, 8'h00);
    en_b    = last && !skip_n;
    pa = en_a ? code_a.prim : sdpe_pkg::SymNone;
    sa = en_a ? code_a.sec  : sdpe_pkg::SymNone;
    pb = en_b ? code_b.prim : sdpe_pkg::SymNone;
    sb = en_b ? code_b.sec  : sdpe_pkg::SymNone;
  end

  sdpe_code_acc #(.Limit(SymLimit)) u_prim (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (accept),
    .clr_i   (last),
    .sym_a_i (pa),
    .sym_b_i (pb),
    .code_o  (prim_code),
    .len_o   (prim_len)
  );

  sdpe_code_acc #(.Limit(SymLimit)) u_sec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (accept),
    .clr_i   (last),
    .sym_a_i (sa),
    .sym_b_i (sb),
    .code_o  (sec_code),
    .len_o   (sec_len)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_char_q  <= '0;
      pend_valid_q <= 1'b0;
      pend_first_q <= 1'b1;
      skip_q       <= 1'b0;
    end else if (accept) begin
      if (last) begin
        pend_char_q  <= '0;
        pend_valid_q <= 1'b0;
        pend_first_q <= 1'b1;
        skip_q       <= 1'b0;
      end else begin
        pend_char_q  <= c;
        pend_valid_q <= 1'b1;
        pend_first_q <= first_n;
        skip_q       <= skip_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      out_data_q.main_code        <= prim_code;
      out_data_q.primary_length   <= prim_len;
      out_data_q.alt_code         <= sec_code;
      out_data_q.secondary_length <= sec_len;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_end_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> out_valid_o)
    else $error("word end did not produce a result");

  a_end_clears_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> !pend_valid_q && pend_first_q && !skip_q)
    else $error("lookahead state not cleared at word end");

  a_skip_needs_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> pend_valid_q && !pend_first_q)
    else $error("digraph skip without a held character");

  a_len_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.primary_length <= sdpe_pkg::CntW'(SymLimit)
                 && out_data_o.secondary_length <= sdpe_pkg::CntW'(SymLimit))
    else $error("code length beyond limit");

endmodule

>>> rtl/core/sdpe_code_acc.sv
// Collects one code's symbols; up to two symbols can land per update.
module sdpe_code_acc #(
  parameter int unsigned Limit = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              upd_i,
  input  logic                              clr_i,
  input  logic [sdpe_pkg::SymW-1:0]         sym_a_i,
  input  logic [sdpe_pkg::SymW-1:0]         sym_b_i,
  output logic [sdpe_pkg::CodeW-1:0]        code_o,
  output logic [sdpe_pkg::CntW-1:0]         len_o
);

  localparam logic [sdpe_pkg::CntW-1:0] LimitC = sdpe_pkg::CntW'(Limit);

  logic [sdpe_pkg::SymW-1:0] sym_q [sdpe_pkg::MaxSymbols];
  logic [sdpe_pkg::SymW-1:0] sym_d [sdpe_pkg::MaxSymbols];
  logic [sdpe_pkg::CntW-1:0] cnt_q, cnt_mid, cnt_d;

  always_comb begin
    for (int k = 0; k < sdpe_pkg::MaxSymbols; k++) sym_d[k] = sym_q[k];
    cnt_mid = cnt_q;
    if (sym_a_i != sdpe_pkg::SymNone && cnt_q < LimitC) begin
      for (int k = 0; k < sdpe_pkg::MaxSymbols; k++) begin
        if (sdpe_pkg::CntW'(k) == cnt_q) sym_d[k] = sym_a_i;
      end
      cnt_mid = cnt_q + 1'b1;
    end
    cnt_d = cnt_mid;
    if (sym_b_i != sdpe_pkg::SymNone && cnt_mid < LimitC) begin
      for (int k = 0; k < sdpe_pkg::MaxSymbols; k++) begin
        if (sdpe_pkg::CntW'(k) == cnt_mid) sym_d[k] = sym_b_i;
      end
      cnt_d = cnt_mid + 1'b1;
    end
  end

  always_comb begin
    for (int k = 0; k < sdpe_pkg::MaxSymbols; k++) begin
      code_o[k*sdpe_pkg::SymW +: sdpe_pkg::SymW] = sym_d[k];
    end
    len_o = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < sdpe_pkg::MaxSymbols; k++) sym_q[k] <= '0;
      cnt_q <= '0;
    end else if (upd_i) begin
      if (clr_i) begin
        for (int k = 0; k < sdpe_pkg::MaxSymbols; k++) sym_q[k] <= '0;
        cnt_q <= '0;
      end else begin
        for (int k = 0; k < sdpe_pkg::MaxSymbols; k++) sym_q[k] <= sym_d[k];
        cnt_q <= cnt_d;
      end
    end
  end

endmodule
